[design/perm_pkg.sv]
// perm_pkg: transaction types and operation codes of the permutation enumerator.
// Depends on nothing; used by permutation_enumerator.
`timescale 1ns / 1ps
`default_nettype none

package perm_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_NEXT  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] element;
    logic [2:0] position;
    logic       element_valid;
    logic       last_of_run;
    logic       final_permutation;
    logic       no_more;
  } out_t;

endpackage

`default_nettype wire

[design/permutation_enumerator.sv]
// permutation_enumerator: swap-based backtracking enumeration of a loaded symbol set.
// Depends on perm_pkg (transaction structs, op codes).
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------
// input    | in        | in_valid/in_ready  | perm_pkg::in_t  (op, value)
// result   | out       | out_valid/out_ready| perm_pkg::out_t (6 fields)
//
// Sequence: clear and load finish on acceptance. A next request (n symbols) is
//   accepted, walks back level by level (counter read, pair read, two writes;
//   skipped on the first request), swaps forward (pair read, two writes),
//   reseeds the deeper counters, checks n counters and emits n elements, paced by
//   the single write port of the arrangement memory and registered memory reads.
// Reset: rst_n low clears length, started, exhausted, the sequencer and the
//   output valid flag. The memories are not cleared; every entry is written
//   before it is read.
// Stalls: a held result parks in the output register; the sequencer waits in
//   its emit or single-result state until the register drains. Input is taken
//   only while the sequencer is idle.

module permutation_enumerator #(
  parameter int MAX_LEN    = 8,
  parameter int ELEM_WIDTH = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire perm_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output perm_pkg::out_t      out_data
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;  // memory address
  localparam int LW = $clog2(MAX_LEN + 1);                  // holds 0..MAX_LEN

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ONE    = 4'd1;
  localparam logic [3:0] S_DESC   = 4'd2;
  localparam logic [3:0] S_BK_RD  = 4'd3;
  localparam logic [3:0] S_BK_C   = 4'd4;
  localparam logic [3:0] S_BK_SW1 = 4'd5;
  localparam logic [3:0] S_BK_SW2 = 4'd6;
  localparam logic [3:0] S_FW_RD  = 4'd7;
  localparam logic [3:0] S_FW_SW1 = 4'd8;
  localparam logic [3:0] S_FW_SW2 = 4'd9;
  localparam logic [3:0] S_CHK_RD = 4'd10;
  localparam logic [3:0] S_CHK_EV = 4'd11;
  localparam logic [3:0] S_E_RD   = 4'd12;
  localparam logic [3:0] S_E_OUT  = 4'd13;

  // Memories: arrangement (two read ports, one write) and choice counters.
  logic [ELEM_WIDTH-1:0] arr_mem [MAX_LEN];
  logic [LW-1:0]         ctr_mem [MAX_LEN];

  logic [ELEM_WIDTH-1:0] arr_qa_r, arr_qb_r;
  logic [LW-1:0]         ctr_q_r;

  logic                  arr_we;
  logic [AW-1:0]         arr_wa;
  logic [ELEM_WIDTH-1:0] arr_wd;
  logic [AW-1:0]         arr_ra, arr_rb;
  logic                  ctr_we;
  logic [AW-1:0]         ctr_wa;
  logic [LW-1:0]         ctr_wd;
  logic [AW-1:0]         ctr_ra;

  // Control registers.
  logic [3:0]            state_r, state_nxt;
  logic [LW-1:0]         length_r, length_nxt;
  logic                  started_r, started_nxt;
  logic                  exhausted_r, exhausted_nxt;
  logic [AW-1:0]         k_r, k_nxt;
  logic [LW-1:0]         m_r, m_nxt;
  logic [LW-1:0]         p_r, p_nxt;
  logic [LW-1:0]         c_r, c_nxt;
  logic [ELEM_WIDTH-1:0] hold_r, hold_nxt;
  logic                  fin_r, fin_nxt;
  logic                  one_nomore_r, one_nomore_nxt;
  logic                  out_valid_r, out_valid_nxt;
  perm_pkg::out_t        out_data_r, out_data_nxt;

  logic                    in_fire;
  logic                    out_free;
  logic [ELEM_WIDTH+7:0]   in_ext;
  logic [ELEM_WIDTH+7:0]   elem_ext;
  logic [LW+2:0]           pos_ext;
  logic [LW-1:0]           length_m1;
  logic [LW-1:0]           c_inc;
  logic                    p_last;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_ext    = {{ELEM_WIDTH{1'b0}}, in_data.value};
  assign elem_ext  = {8'b0, arr_qa_r};
  assign pos_ext   = {3'b000, p_r};
  assign length_m1 = length_r - LW'(1);
  assign c_inc     = c_r + LW'(1);
  assign p_last    = (p_r == length_m1);

  // Memory ports: write at the edge leaving a state, reads registered.
  always_ff @(posedge clk) begin
    if (arr_we) begin
      arr_mem[arr_wa] <= arr_wd;
    end
    if (ctr_we) begin
      ctr_mem[ctr_wa] <= ctr_wd;
    end
    arr_qa_r <= arr_mem[arr_ra];
    arr_qb_r <= arr_mem[arr_rb];
    ctr_q_r  <= ctr_mem[ctr_ra];
  end

  always_comb begin
    state_nxt      = state_r;
    length_nxt     = length_r;
    started_nxt    = started_r;
    exhausted_nxt  = exhausted_r;
    k_nxt          = k_r;
    m_nxt          = m_r;
    p_nxt          = p_r;
    c_nxt          = c_r;
    hold_nxt       = hold_r;
    fin_nxt        = fin_r;
    one_nomore_nxt = one_nomore_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    arr_we = 1'b0;
    arr_wa = k_r;
    arr_wd = arr_qb_r;
    arr_ra = k_r;
    arr_rb = c_r[AW-1:0];
    ctr_we = 1'b0;
    ctr_wa = k_r;
    ctr_wd = c_inc;
    ctr_ra = k_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.op)
            perm_pkg::OP_CLEAR: begin
              length_nxt    = '0;
              started_nxt   = 1'b0;
              exhausted_nxt = 1'b0;
            end
            perm_pkg::OP_LOAD: begin
              // Append in present order; drop when full.
              if (length_r < LW'(MAX_LEN)) begin
                arr_we     = 1'b1;
                arr_wa     = length_r[AW-1:0];
                arr_wd     = in_ext[ELEM_WIDTH-1:0];
                length_nxt = length_r + LW'(1);
              end
              started_nxt   = 1'b0;
              exhausted_nxt = 1'b0;
            end
            perm_pkg::OP_NEXT: begin
              if (exhausted_r) begin
                one_nomore_nxt = 1'b1;
                state_nxt      = S_ONE;
              end else if (!started_r) begin
                started_nxt = 1'b1;
                m_nxt       = '0;
                state_nxt   = S_DESC;
              end else if (length_r == '0) begin
                exhausted_nxt  = 1'b1;
                one_nomore_nxt = 1'b1;
                state_nxt      = S_ONE;
              end else begin
                k_nxt     = length_m1[AW-1:0];
                state_nxt = S_BK_RD;
              end
            end
            default: begin
              // Unused op code: ignore.
            end
          endcase
        end
      end
      S_ONE: begin
        // Single result: empty permutation or nothing left.
        if (out_free) begin
          out_valid_nxt                   = 1'b1;
          out_data_nxt.element            = '0;
          out_data_nxt.position           = '0;
          out_data_nxt.element_valid      = 1'b0;
          out_data_nxt.last_of_run        = 1'b1;
          out_data_nxt.final_permutation  = !one_nomore_r;
          out_data_nxt.no_more            = one_nomore_r;
          state_nxt                       = S_IDLE;
        end
      end
      S_DESC: begin
        // Reseed deeper levels: counter at level m starts at m.
        if (m_r < length_r) begin
          ctr_we = 1'b1;
          ctr_wa = m_r[AW-1:0];
          ctr_wd = m_r;
          m_nxt  = m_r + LW'(1);
        end else if (length_r == '0) begin
          one_nomore_nxt = 1'b0;
          state_nxt      = S_ONE;
        end else begin
          p_nxt     = '0;
          fin_nxt   = 1'b1;
          state_nxt = S_CHK_RD;
        end
      end
      S_BK_RD: begin
        ctr_ra    = k_r;
        state_nxt = S_BK_C;
      end
      S_BK_C: begin
        c_nxt     = ctr_q_r;
        arr_ra    = k_r;
        arr_rb    = ctr_q_r[AW-1:0];
        state_nxt = S_BK_SW1;
      end
      S_BK_SW1: begin
        // Undo the swap at this level and advance its counter.
        arr_we    = 1'b1;
        arr_wa    = k_r;
        arr_wd    = arr_qb_r;
        hold_nxt  = arr_qa_r;
        ctr_we    = 1'b1;
        ctr_wa    = k_r;
        ctr_wd    = c_inc;
        state_nxt = S_BK_SW2;
      end
      S_BK_SW2: begin
        arr_we = 1'b1;
        arr_wa = c_r[AW-1:0];
        arr_wd = hold_r;
        if (c_inc < length_r) begin
          c_nxt     = c_inc;
          state_nxt = S_FW_RD;
        end else if (k_r == '0) begin
          exhausted_nxt  = 1'b1;
          one_nomore_nxt = 1'b1;
          state_nxt      = S_ONE;
        end else begin
          k_nxt     = k_r - AW'(1);
          state_nxt = S_BK_RD;
        end
      end
      S_FW_RD: begin
        arr_ra    = k_r;
        arr_rb    = c_r[AW-1:0];
        state_nxt = S_FW_SW1;
      end
      S_FW_SW1: begin
        arr_we    = 1'b1;
        arr_wa    = k_r;
        arr_wd    = arr_qb_r;
        hold_nxt  = arr_qa_r;
        state_nxt = S_FW_SW2;
      end
      S_FW_SW2: begin
        arr_we    = 1'b1;
        arr_wa    = c_r[AW-1:0];
        arr_wd    = hold_r;
        m_nxt     = LW'(k_r) + LW'(1);
        state_nxt = S_DESC;
      end
      S_CHK_RD: begin
        ctr_ra    = p_r[AW-1:0];
        state_nxt = S_CHK_EV;
      end
      S_CHK_EV: begin
        // Final permutation: every counter sits on the last index.
        if (ctr_q_r != length_m1) begin
          fin_nxt = 1'b0;
        end
        if (p_last) begin
          p_nxt     = '0;
          state_nxt = S_E_RD;
        end else begin
          p_nxt     = p_r + LW'(1);
          state_nxt = S_CHK_RD;
        end
      end
      S_E_RD: begin
        arr_ra    = p_r[AW-1:0];
        state_nxt = S_E_OUT;
      end
      S_E_OUT: begin
        // Hold the read data until the output register drains.
        arr_ra = p_r[AW-1:0];
        if (out_free) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.element           = elem_ext[7:0];
          out_data_nxt.position          = pos_ext[2:0];
          out_data_nxt.element_valid     = 1'b1;
          out_data_nxt.last_of_run       = p_last;
          out_data_nxt.final_permutation = fin_r;
          out_data_nxt.no_more           = 1'b0;
          if (p_last) begin
            state_nxt = S_IDLE;
          end else begin
            p_nxt     = p_r + LW'(1);
            state_nxt = S_E_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      length_r    <= '0;
      started_r   <= 1'b0;
      exhausted_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      length_r    <= length_nxt;
      started_r   <= started_nxt;
      exhausted_r <= exhausted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    m_r          <= m_nxt;
    p_r          <= p_nxt;
    c_r          <= c_nxt;
    hold_r       <= hold_nxt;
    fin_r        <= fin_nxt;
    one_nomore_r <= one_nomore_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Checks on the sequencer.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= LW'(MAX_LEN))
    else $error("length beyond capacity");

  a_exh_started: assert property (@(posedge clk) disable iff (!rst_n)
    exhausted_r |-> started_r)
    else $error("exhausted without a started enumeration");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BK_RD || state_r == S_BK_SW2 || state_r == S_FW_SW2)
      |-> (LW'(k_r) < length_r))
    else $error("backtrack level outside the set");

  a_nomore_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.no_more)
      |-> (out_data.last_of_run && !out_data.element_valid && !out_data.final_permutation))
    else $error("malformed exhausted result");

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_E_OUT && out_free) |=> (out_valid && out_data.element_valid))
    else $error("emitted element not loaded");

endmodule

`default_nettype wire
